### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cook controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OCC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define OCC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/occ_pkg.sv
// ----------------------------------------------------------------------------
// occ_pkg
// Types and codes shared by the cook controller modules.
// ----------------------------------------------------------------------------
package occ_pkg;

  localparam int POT_W     = 10;
  localparam int TEMP_W    = 10;
  localparam int SET_W     = 9;
  localparam int CD_W      = 10;
  localparam int TICK_W    = 16;
  localparam int LPT_W     = 8;
  localparam int LED_BAR_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  // event kinds
  localparam logic [1:0] KIND_POT   = 2'd0;
  localparam logic [1:0] KIND_BTN   = 2'd1;
  localparam logic [1:0] KIND_HALF  = 2'd2;
  localparam logic [1:0] KIND_FIFTH = 2'd3;

  // button edges
  localparam logic [1:0] BTN3_DOWN = 2'd0;
  localparam logic [1:0] BTN3_UP   = 2'd1;
  localparam logic [1:0] BTN4_DOWN = 2'd2;
  localparam logic [1:0] BTN4_UP   = 2'd3;

  // machine states
  localparam logic [2:0] PH_RESET  = 3'd0;
  localparam logic [2:0] PH_SETUP  = 3'd1;
  localparam logic [2:0] PH_COUNT  = 3'd2;
  localparam logic [2:0] PH_CANCEL = 3'd3;
  localparam logic [2:0] PH_SELECT = 3'd4;

  // cook modes
  localparam logic [1:0] MODE_BAKE  = 2'd0;
  localparam logic [1:0] MODE_TOAST = 2'd1;
  localparam logic [1:0] MODE_BROIL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TEMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BROIL_TEMP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd3;

  // configuration reset values
  localparam logic [TEMP_W-1:0] DEFAULT_TEMP_RST = 10'd300;
  localparam logic [TEMP_W-1:0] BROIL_TEMP_RST   = 10'd500;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET_RST  = 10'd300;
  localparam logic [LPT_W-1:0]  LONG_PRESS_RST   = 8'd5;

  typedef struct packed {
    logic [1:0]       kind;
    logic [POT_W-1:0] pot_value;
    logic [1:0]       button_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           machine_state;
    logic [1:0]           cook_mode;
    logic                 selector_is_temp;
    logic [TEMP_W-1:0]    temperature;
    logic [SET_W-1:0]     set_seconds;
    logic [CD_W-1:0]      half_seconds_left;
    logic                 heater_on;
    logic [LED_BAR_W-1:0] led_bar;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic div_start;
    logic led_load;
    logic check;
    logic publish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_needed;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/occ_stream_if.sv
// ----------------------------------------------------------------------------
// occ_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface occ_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/occ_div.sv
// ----------------------------------------------------------------------------
// occ_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module occ_div #(
  parameter int NUM_W = 14,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### hw/rtl/occ_ctrl.sv
// ----------------------------------------------------------------------------
// occ_ctrl
// Sequencer: accept, apply event, optional LED divide, hold check, publish.
// ----------------------------------------------------------------------------
module occ_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  occ_pkg::dp_status_t sts,
  output occ_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_CHECK,
    S_PUB
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.div_start = sts.div_needed;
        state_nxt     = sts.div_needed ? S_DIV : S_CHECK;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.led_load = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_PUB;
      end
      S_PUB: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/occ_dp.sv
// ----------------------------------------------------------------------------
// occ_dp
// Cook state registers, event update logic, LED divider and result register.
// ----------------------------------------------------------------------------
module occ_dp #(
  parameter int LED_COUNT = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  occ_pkg::in_item_t                   in_data,
  input  occ_pkg::ctrl_cmd_t                  cmd,
  output occ_pkg::dp_status_t                 sts,
  input  logic                                cfg_we,
  input  logic [occ_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [occ_pkg::CFG_DAT_W-1:0]       cfg_wdata,
  input  logic                                out_ready,
  output logic                                out_valid,
  output occ_pkg::out_item_t                  out_data
);

  localparam int LVL_W = $clog2(LED_COUNT + 1);
  localparam int NUM_W = occ_pkg::CD_W + LVL_W;
  localparam int TW    = occ_pkg::TEMP_W;
  localparam int SW    = occ_pkg::SET_W;
  localparam int CW    = occ_pkg::CD_W;
  localparam int KW    = occ_pkg::TICK_W;

  // configuration
  logic [TW-1:0]               def_temp_r, broil_temp_r, offset_r;
  logic [occ_pkg::LPT_W-1:0]   lpt_r;

  // cook state
  occ_pkg::in_item_t           ev_r, ev_nxt;
  logic [2:0]                  phase_r, phase_nxt;
  logic [1:0]                  mode_r, mode_nxt;
  logic                        sel_r, sel_nxt;
  logic [TW-1:0]               temp_r, temp_nxt;
  logic [SW-1:0]               set_r, set_nxt;
  logic [CW-1:0]               cd_r, cd_nxt;
  logic                        heat_r, heat_nxt;
  logic [KW-1:0]               tick_r, tick_nxt;
  logic [KW-1:0]               press_r, press_nxt;
  logic [occ_pkg::LED_BAR_W-1:0] led_r, led_nxt;
  logic [occ_pkg::POT_W-1:0]   pot_r, pot_nxt;

  logic                        out_valid_r;
  occ_pkg::out_item_t          out_r;

  logic [2:0]                  phase_n;
  logic [1:0]                  mode_n;
  logic                        held_long;
  logic                        go_reset;
  logic                        sel_tmp;
  logic                        in_count;
  logic [CW-1:0]               cd_dec;
  logic [NUM_W-1:0]            div_num;
  logic [NUM_W-1:0]            div_quo;
  logic                        div_done;
  logic [LVL_W-1:0]            lvl;

  function automatic logic [TW-1:0] pot_to_temp(input logic [occ_pkg::POT_W-1:0] pot,
                                                input logic [TW-1:0] offs);
    logic [TW:0] sum;
    sum = (TW+1)'(pot[occ_pkg::POT_W-1:2]) + (TW+1)'(offs);
    return sum[TW] ? '1 : sum[TW-1:0];
  endfunction

  function automatic logic [SW-1:0] pot_to_time(input logic [occ_pkg::POT_W-1:0] pot);
    return SW'(pot[occ_pkg::POT_W-1:2]) + SW'(1);
  endfunction

  // invalid codes fold to setup / bake
  assign phase_n = (phase_r == occ_pkg::PH_RESET || phase_r > occ_pkg::PH_SELECT)
                   ? occ_pkg::PH_SETUP : phase_r;
  assign mode_n  = (mode_r > occ_pkg::MODE_BROIL) ? occ_pkg::MODE_BAKE : mode_r;

  assign held_long = (KW'(tick_r - press_r) >= KW'(lpt_r));
  assign in_count  = (phase_n == occ_pkg::PH_COUNT) || (phase_n == occ_pkg::PH_CANCEL);
  assign cd_dec    = cd_r - CW'(1);
  assign div_num   = NUM_W'(cd_dec) * NUM_W'(LED_COUNT);

  assign sts.div_needed = (ev_r.kind == occ_pkg::KIND_HALF) && in_count && (cd_r != '0);
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid_r || out_ready;

  occ_div #(
    .NUM_W (NUM_W),
    .DEN_W (SW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (set_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // min(quotient + 1, LED_COUNT); zero set time gives the full bar
  always_comb begin
    if (set_r == '0 || div_quo >= NUM_W'(LED_COUNT)) begin
      lvl = LVL_W'(LED_COUNT);
    end else begin
      lvl = LVL_W'(div_quo) + LVL_W'(1);
    end
  end

  always_comb begin
    ev_nxt    = ev_r;
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    sel_nxt   = sel_r;
    temp_nxt  = temp_r;
    set_nxt   = set_r;
    cd_nxt    = cd_r;
    heat_nxt  = heat_r;
    tick_nxt  = tick_r;
    press_nxt = press_r;
    led_nxt   = led_r;
    pot_nxt   = pot_r;
    go_reset  = 1'b0;
    sel_tmp   = sel_r;

    if (cmd.latch) ev_nxt = in_data;

    if (cmd.exec) begin
      phase_nxt = phase_n;
      mode_nxt  = mode_n;
      case (ev_r.kind)
        occ_pkg::KIND_POT: begin
          pot_nxt = ev_r.pot_value;
          if (phase_n == occ_pkg::PH_SETUP) begin
            if (sel_r) temp_nxt = pot_to_temp(ev_r.pot_value, offset_r);
            else       set_nxt  = pot_to_time(ev_r.pot_value);
          end
        end
        occ_pkg::KIND_FIFTH: begin
          tick_nxt = tick_r + KW'(1);
        end
        occ_pkg::KIND_HALF: begin
          if (in_count) begin
            if (cd_r == '0) go_reset = 1'b1;
            else            cd_nxt   = cd_dec;
          end
        end
        default: begin
          case (phase_n)
            occ_pkg::PH_SETUP: begin
              if (ev_r.button_code == occ_pkg::BTN4_DOWN) begin
                cd_nxt    = {set_r, 1'b0};
                heat_nxt  = 1'b1;
                phase_nxt = occ_pkg::PH_COUNT;
              end else if (ev_r.button_code == occ_pkg::BTN3_DOWN) begin
                press_nxt = tick_r;
                phase_nxt = occ_pkg::PH_SELECT;
              end
            end
            occ_pkg::PH_SELECT: begin
              if (ev_r.button_code == occ_pkg::BTN3_UP) begin
                if (!held_long) begin
                  // short press: next mode
                  case (mode_n)
                    occ_pkg::MODE_BAKE: begin
                      mode_nxt = occ_pkg::MODE_TOAST;
                      temp_nxt = '0;
                    end
                    occ_pkg::MODE_TOAST: begin
                      mode_nxt = occ_pkg::MODE_BROIL;
                      temp_nxt = broil_temp_r;
                    end
                    default: begin
                      mode_nxt = occ_pkg::MODE_BAKE;
                      temp_nxt = def_temp_r;
                    end
                  endcase
                  set_nxt = '0;
                  sel_nxt = 1'b0;
                end else begin
                  // long press: flip selector (bake only), reload target
                  if (mode_n == occ_pkg::MODE_BAKE) begin
                    sel_tmp = ~sel_r;
                    if (sel_tmp) temp_nxt = pot_to_temp(pot_r, offset_r);
                  end
                  if (!sel_tmp) set_nxt = pot_to_time(pot_r);
                  sel_nxt = sel_tmp;
                end
                phase_nxt = occ_pkg::PH_SETUP;
              end
            end
            occ_pkg::PH_COUNT: begin
              if (ev_r.button_code == occ_pkg::BTN4_DOWN) begin
                press_nxt = tick_r;
                phase_nxt = occ_pkg::PH_CANCEL;
              end
            end
            occ_pkg::PH_CANCEL: begin
              if (ev_r.button_code == occ_pkg::BTN4_UP) phase_nxt = occ_pkg::PH_COUNT;
            end
            default: ;
          endcase
        end
      endcase
    end

    if (cmd.led_load) begin
      if (32'(lvl) >= occ_pkg::LED_BAR_W) led_nxt = '1;
      else                                led_nxt = ~({occ_pkg::LED_BAR_W{1'b1}} >> lvl);
    end

    if (cmd.check && phase_r == occ_pkg::PH_CANCEL && held_long) go_reset = 1'b1;

    if (go_reset) begin
      sel_nxt   = 1'b0;
      temp_nxt  = def_temp_r;
      heat_nxt  = 1'b0;
      set_nxt   = SW'(1);
      led_nxt   = '0;
      phase_nxt = occ_pkg::PH_SETUP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_temp_r   <= occ_pkg::DEFAULT_TEMP_RST;
      broil_temp_r <= occ_pkg::BROIL_TEMP_RST;
      offset_r     <= occ_pkg::TEMP_OFFSET_RST;
      lpt_r        <= occ_pkg::LONG_PRESS_RST;
      phase_r      <= occ_pkg::PH_SETUP;
      mode_r       <= occ_pkg::MODE_BAKE;
      sel_r        <= 1'b0;
      temp_r       <= occ_pkg::DEFAULT_TEMP_RST;
      set_r        <= '0;
      cd_r         <= '0;
      heat_r       <= 1'b0;
      tick_r       <= '0;
      press_r      <= '0;
      led_r        <= '0;
      pot_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          occ_pkg::CFG_DEFAULT_TEMP: def_temp_r   <= cfg_wdata;
          occ_pkg::CFG_BROIL_TEMP:   broil_temp_r <= cfg_wdata;
          occ_pkg::CFG_TEMP_OFFSET:  offset_r     <= cfg_wdata;
          occ_pkg::CFG_LONG_PRESS:   lpt_r        <= cfg_wdata[occ_pkg::LPT_W-1:0];
          default: ;
        endcase
      end
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      sel_r   <= sel_nxt;
      temp_r  <= temp_nxt;
      set_r   <= set_nxt;
      cd_r    <= cd_nxt;
      heat_r  <= heat_nxt;
      tick_r  <= tick_nxt;
      press_r <= press_nxt;
      led_r   <= led_nxt;
      pot_r   <= pot_nxt;
      if (cmd.publish)    out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    ev_r <= ev_nxt;
    if (cmd.publish) begin
      out_r.machine_state     <= phase_r;
      out_r.cook_mode         <= mode_r;
      out_r.selector_is_temp  <= sel_r;
      out_r.temperature       <= temp_r;
      out_r.set_seconds       <= set_r;
      out_r.half_seconds_left <= cd_r;
      out_r.heater_on         <= heat_r;
      out_r.led_bar           <= led_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/oven_cook_controller.sv
// ----------------------------------------------------------------------------
// oven_cook_controller
// Event-driven cook controller for a small countertop oven.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one event per transfer (pot sample, button edge, half-second
//            tick, fifth-second tick). Every event gives exactly one result.
//   out_ch : snapshot of the controller after the event (state, mode,
//            selector, temperature, set time, countdown, heater, LED bar).
//   cfg_*  : write-only register port (default temp, broil temp, temp
//            offset, long-press ticks); write only while the block is idle.
// Flow: each event is latched, applied, hold-checked and then published
//   into the result register. A half-second tick that decrements the
//   countdown also runs the LED divider, one quotient bit per cycle,
//   between the apply and hold-check steps.
// Handshake: one event at a time; in_ch.ready is high only while the
//   sequencer is idle. A finished result sits in the output register,
//   so the next event is taken while out_ch is stalled; that event then
//   waits in the publish step until the output register is taken.
// Reset: synchronous, active low. Setup state, bake mode, time selector,
//   temperature 300, zero set time and countdown, heater off, LEDs dark.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oven_cook_controller #(
  parameter int LED_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  occ_stream_if.sink                    in_ch,
  occ_stream_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [occ_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [occ_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  occ_pkg::ctrl_cmd_t  cmd;
  occ_pkg::dp_status_t sts;
  occ_pkg::in_item_t   in_item;
  occ_pkg::out_item_t  out_item;
  logic                in_ready;
  logic                out_valid;

  assign in_item      = in_ch.data;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  // sequencer
  occ_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // cook state, LED divider, result register
  occ_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_data  (out_item)
  );

  // one event in flight: no transfer right after a transfer
  `OCC_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ready, !in_ready)

  // heater only runs while counting down or waiting on a cancel hold
  `OCC_ASSERT_IMP(a_heater_state, clk, rst_n, out_valid && out_item.heater_on,
    out_item.machine_state == occ_pkg::PH_COUNT ||
    out_item.machine_state == occ_pkg::PH_CANCEL)

  // LED bar is a thermometer from the top bit down
  `OCC_ASSERT_IMP(a_led_thermo, clk, rst_n, out_valid,
    ((~out_item.led_bar) & ((~out_item.led_bar) + 8'd1)) == 8'd0)

  // publish never overwrites a result still waiting
  `OCC_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.publish, !out_valid || out_ch.ready)

endmodule
